// File: rtl/core/quad_cascaded_pd_mixer_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the quad PD mixer unit
// Shared property forms used by the checker.
// ----------------------------------------------------------------------------
`ifndef QUAD_CASCADED_PD_MIXER_UNIT_DEFINES_SVH
`define QUAD_CASCADED_PD_MIXER_UNIT_DEFINES_SVH

// same-cycle implication
`define QCPDM_ASSERT(label, clk, dis, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define QCPDM_ASSERT_NXT(label, clk, dis, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/qcpdm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qcpdm_pkg
// Types, constants and the motor mix function of the quad PD mixer unit.
// ----------------------------------------------------------------------------
package qcpdm_pkg;

  typedef logic signed [15:0] ang_t;
  typedef logic        [7:0]  speed_t;
  typedef logic        [14:0] gain_t;
  typedef logic signed [17:0] corr_t;
  typedef logic        [2:0]  cfg_idx_t;

  typedef struct packed {
    speed_t plus;
    speed_t minus;
  } mix_t;

  localparam cfg_idx_t REG_YAW_KP   = 3'd0;
  localparam cfg_idx_t REG_YAW_KD   = 3'd1;
  localparam cfg_idx_t REG_ROLL_KP  = 3'd2;
  localparam cfg_idx_t REG_ROLL_KD  = 3'd3;
  localparam cfg_idx_t REG_PITCH_KP = 3'd4;
  localparam cfg_idx_t REG_PITCH_KD = 3'd5;
  localparam cfg_idx_t REG_MIN_SPD  = 3'd6;
  localparam cfg_idx_t REG_MAX_SPD  = 3'd7;

  localparam int     NTERM        = 6;
  localparam int     NAXIS        = 3;
  localparam int     NSTAGE       = 6;
  localparam int     CFG_W        = 15;
  localparam speed_t MIN_SPD_RST  = 8'd10;
  localparam speed_t MAX_SPD_RST  = 8'd60;

  // x / 60000 == (x >> 5) / 1875
  localparam int          DEN_SHIFT   = 5;
  localparam logic [10:0] DEN_ODD     = 11'd1875;
  localparam logic [21:0] RECIP       = 22'd2290649;  // floor(2^32 / 1875)

  function automatic mix_t mix(speed_t base, corr_t c, speed_t lo, speed_t hi);
    logic signed [19:0] p;
    logic signed [19:0] m;
    logic signed [19:0] lo_s;
    logic signed [19:0] hi_s;
    mix_t r;
    p    = $signed({12'b0, base}) + 20'(c);
    m    = $signed({12'b0, base}) - 20'(c);
    lo_s = $signed({12'b0, lo});
    hi_s = $signed({12'b0, hi});
    if (c > 0) begin
      r.plus  = (p > hi_s) ? hi : p[7:0];
      r.minus = (m < lo_s) ? lo : m[7:0];
    end else begin
      r.plus  = (p < lo_s) ? lo : p[7:0];
      r.minus = (m > hi_s) ? hi : m[7:0];
    end
    return r;
  endfunction

endpackage

// File: rtl/core/quad_cascaded_pd_mixer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quad_cascaded_pd_mixer_unit
// Yaw, roll and pitch PD loops with a cascaded plus-form motor mixer.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one sensor transaction (setpoints, angles, gyro rates, throttle,
//           arm flag) under valid/ready.
//   out_* : four motor duties and the three PD corrections under valid/ready.
//   cfg_* : gain and clamp registers, written while no transaction is in
//           flight; index 0..7 = yaw kp/kd, roll kp/kd, pitch kp/kd,
//           min speed, max speed.
//   An accepted transaction passes through the stage registers to out_valid.
//   One transaction is taken every cycle while out_ready keeps the output
//   moving: the six stages are gain multiply, reciprocal multiply, quotient
//   fixup, PD sum, yaw mix and roll/pitch mix into the output register.
//   Each stage advances on its own, so bubbles collapse; while the output is
//   held by a low out_ready the stages behind it keep filling, and in_ready
//   falls only when all six hold data.
//   Reset empties the pipeline, gains go to 0, min/max speed to 10/60.
// ----------------------------------------------------------------------------
module quad_cascaded_pd_mixer_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  qcpdm_pkg::ang_t     in_yaw_setpoint,
  input  qcpdm_pkg::ang_t     in_pitch_setpoint,
  input  qcpdm_pkg::ang_t     in_roll_setpoint,
  input  qcpdm_pkg::speed_t   in_throttle_base,
  input  qcpdm_pkg::ang_t     in_yaw_angle,
  input  qcpdm_pkg::ang_t     in_pitch_angle,
  input  qcpdm_pkg::ang_t     in_roll_angle,
  input  qcpdm_pkg::ang_t     in_rate_x,
  input  qcpdm_pkg::ang_t     in_rate_y,
  input  qcpdm_pkg::ang_t     in_rate_z,
  input  logic                in_arm_flag,
  output logic                out_valid,
  input  logic                out_ready,
  output qcpdm_pkg::speed_t   out_motor1_duty,
  output qcpdm_pkg::speed_t   out_motor2_duty,
  output qcpdm_pkg::speed_t   out_motor3_duty,
  output qcpdm_pkg::speed_t   out_motor4_duty,
  output qcpdm_pkg::corr_t    out_yaw_correction,
  output qcpdm_pkg::corr_t    out_roll_correction,
  output qcpdm_pkg::corr_t    out_pitch_correction,
  input  logic                cfg_we,
  input  qcpdm_pkg::cfg_idx_t cfg_index,
  input  logic [14:0]         cfg_wdata
);
  import qcpdm_pkg::*;

  // configuration
  gain_t  gain_r [NTERM];
  speed_t min_r;
  speed_t max_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NTERM; i++) begin
        gain_r[i] <= '0;
      end
      min_r <= MIN_SPD_RST;
      max_r <= MAX_SPD_RST;
    end else if (cfg_we) begin
      case (cfg_index) inside
        REG_YAW_KP, REG_YAW_KD, REG_ROLL_KP,
        REG_ROLL_KD, REG_PITCH_KP, REG_PITCH_KD: begin
          gain_r[cfg_index] <= cfg_wdata;
        end
        REG_MIN_SPD: begin
          min_r <= cfg_wdata[7:0];
        end
        REG_MAX_SPD: begin
          max_r <= cfg_wdata[7:0];
        end
        default: begin
        end
      endcase
    end
  end

  // pipeline control
  logic [NSTAGE-1:0] vld_r;
  logic [NSTAGE-1:0] adv;

  always_comb begin
    adv[NSTAGE-1] = !vld_r[NSTAGE-1] || out_ready;
    for (int k = NSTAGE - 2; k >= 0; k--) begin
      adv[k] = !vld_r[k] || adv[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (adv[0]) begin
        vld_r[0] <= in_valid;
      end
      for (int k = 1; k < NSTAGE; k++) begin
        if (adv[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  assign in_ready  = adv[0];
  assign out_valid = vld_r[NSTAGE-1];

  // stage A: |gain * operand| with sign
  logic signed [16:0] opnd [NTERM];
  logic        [15:0] opnd_abs [NTERM];
  logic        [30:0] a_mag_nxt [NTERM];
  logic        [30:0] a_mag_r [NTERM];
  logic               a_neg_r [NTERM];
  speed_t             a_base_r;
  logic               a_arm_r;

  always_comb begin
    opnd[0] = 17'(in_yaw_setpoint) - 17'(in_yaw_angle);
    opnd[1] = -17'(in_rate_z);
    opnd[2] = 17'(in_roll_setpoint) - 17'(in_roll_angle);
    opnd[3] = -17'(in_rate_x);
    opnd[4] = 17'(in_pitch_setpoint) - 17'(in_pitch_angle);
    opnd[5] = -17'(in_rate_y);
    for (int i = 0; i < NTERM; i++) begin
      opnd_abs[i]  = opnd[i][16] ? 16'(-opnd[i]) : opnd[i][15:0];
      a_mag_nxt[i] = 31'(gain_r[i]) * 31'(opnd_abs[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      for (int i = 0; i < NTERM; i++) begin
        a_mag_r[i] <= a_mag_nxt[i];
        a_neg_r[i] <= opnd[i][16];
      end
      a_base_r <= in_throttle_base;
      a_arm_r  <= in_arm_flag;
    end
  end

  // stage B: quotient estimate, low by at most one
  logic [25:0] b_x_nxt [NTERM];
  logic [47:0] b_prod [NTERM];
  logic [25:0] b_x_r [NTERM];
  logic [15:0] b_est_r [NTERM];
  logic        b_neg_r [NTERM];
  speed_t      b_base_r;
  logic        b_arm_r;

  always_comb begin
    for (int i = 0; i < NTERM; i++) begin
      b_x_nxt[i] = a_mag_r[i][30:DEN_SHIFT];
      b_prod[i]  = 48'(b_x_nxt[i]) * 48'(RECIP);
    end
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      for (int i = 0; i < NTERM; i++) begin
        b_x_r[i]   <= b_x_nxt[i];
        b_est_r[i] <= b_prod[i][47:32];
        b_neg_r[i] <= a_neg_r[i];
      end
      b_base_r <= a_base_r;
      b_arm_r  <= a_arm_r;
    end
  end

  // stage C: remainder fixup and sign
  logic [26:0] c_rem [NTERM];
  logic [16:0] c_q [NTERM];
  corr_t       c_term_r [NTERM];
  speed_t      c_base_r;
  logic        c_arm_r;

  always_comb begin
    for (int i = 0; i < NTERM; i++) begin
      c_rem[i] = 27'(b_x_r[i]) - 27'(b_est_r[i]) * 27'(DEN_ODD);
      c_q[i]   = 17'(b_est_r[i]) + 17'(c_rem[i] >= 27'(DEN_ODD));
    end
  end

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      for (int i = 0; i < NTERM; i++) begin
        c_term_r[i] <= b_neg_r[i] ? -18'(c_q[i]) : 18'(c_q[i]);
      end
      c_base_r <= b_base_r;
      c_arm_r  <= b_arm_r;
    end
  end

  // stage D: PD sums (yaw, roll, pitch)
  corr_t  d_corr_r [NAXIS];
  speed_t d_base_r;
  logic   d_arm_r;

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      for (int j = 0; j < NAXIS; j++) begin
        d_corr_r[j] <= c_term_r[2*j] + c_term_r[2*j+1];
      end
      d_base_r <= c_base_r;
      d_arm_r  <= c_arm_r;
    end
  end

  // stage E: yaw split into roll and pitch bases
  mix_t   yaw_mix;
  speed_t e_rbase_r;
  speed_t e_pbase_r;
  corr_t  e_yc_r;
  corr_t  e_rc_r;
  corr_t  e_pc_r;
  logic   e_arm_r;

  assign yaw_mix = mix(d_base_r, d_corr_r[0], min_r, max_r);

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      e_rbase_r <= yaw_mix.plus;
      e_pbase_r <= yaw_mix.minus;
      e_yc_r    <= d_corr_r[0];
      e_rc_r    <= d_corr_r[1];
      e_pc_r    <= d_corr_r[2];
      e_arm_r   <= d_arm_r;
    end
  end

  // stage F: roll and pitch mix into the output register
  mix_t   roll_mix;
  mix_t   pitch_mix;
  speed_t f_m1_r;
  speed_t f_m2_r;
  speed_t f_m3_r;
  speed_t f_m4_r;
  corr_t  f_yc_r;
  corr_t  f_rc_r;
  corr_t  f_pc_r;

  assign roll_mix  = mix(e_rbase_r, e_rc_r, min_r, max_r);
  assign pitch_mix = mix(e_pbase_r, e_pc_r, min_r, max_r);

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      f_m1_r <= e_arm_r ? pitch_mix.plus  : '0;
      f_m2_r <= e_arm_r ? roll_mix.minus  : '0;
      f_m3_r <= e_arm_r ? roll_mix.plus   : '0;
      f_m4_r <= e_arm_r ? pitch_mix.minus : '0;
      f_yc_r <= e_yc_r;
      f_rc_r <= e_rc_r;
      f_pc_r <= e_pc_r;
    end
  end

  assign out_motor1_duty      = f_m1_r;
  assign out_motor2_duty      = f_m2_r;
  assign out_motor3_duty      = f_m3_r;
  assign out_motor4_duty      = f_m4_r;
  assign out_yaw_correction   = f_yc_r;
  assign out_roll_correction  = f_rc_r;
  assign out_pitch_correction = f_pc_r;

endmodule

// File: rtl/core/qcpdm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qcpdm_checker
// Port-level checks of the quad PD mixer unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "quad_cascaded_pd_mixer_unit_defines.svh"

module qcpdm_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input qcpdm_pkg::speed_t out_motor1_duty,
  input qcpdm_pkg::speed_t out_motor2_duty,
  input qcpdm_pkg::speed_t out_motor3_duty,
  input qcpdm_pkg::speed_t out_motor4_duty,
  input qcpdm_pkg::corr_t  out_yaw_correction,
  input qcpdm_pkg::corr_t  out_roll_correction,
  input qcpdm_pkg::corr_t  out_pitch_correction
);
  import qcpdm_pkg::*;

  logic [85:0] out_pl;
  logic        out_hold;

  assign out_pl = {out_motor1_duty, out_motor2_duty, out_motor3_duty, out_motor4_duty,
                   out_yaw_correction, out_roll_correction, out_pitch_correction};
  assign out_hold = out_valid && !out_ready;

  `QCPDM_ASSERT_NXT(a_rst_empty, clk, 1'b0, !rst_n, !out_valid, "output valid after reset")
  `QCPDM_ASSERT_NXT(a_out_hold, clk, !rst_n, out_hold, out_valid && $stable(out_pl), "stall")
  `QCPDM_ASSERT(a_ready_empty, clk, !rst_n, !out_valid, in_ready, "input blocked while empty")
  `QCPDM_ASSERT(a_roll_zero, clk, !rst_n, out_valid && out_roll_correction == 0, out_motor2_duty <= out_motor3_duty, "roll mix order")
  `QCPDM_ASSERT(a_pitch_zero, clk, !rst_n, out_valid && out_pitch_correction == 0, out_motor4_duty <= out_motor1_duty, "pitch mix order")

endmodule

bind quad_cascaded_pd_mixer_unit qcpdm_checker u_qcpdm_checker (.*);
